// ===== rtl/core/erp_pkg.sv =====
package erp_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CW_BITS = 34;
  localparam int TRIG_BITS = 18;
  localparam int MAT_BITS = 20;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef logic signed [MAT_BITS-1:0] mat_t;

endpackage

// ===== rtl/core/euler_rotate_3d_point.sv =====
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   coord_x/y/z, angle_x/y/z
// out_      output     out_valid/out_stall rot_x/y/z, saturated
//
// fully pipelined, one transfer per cycle unless out_stall holds the pipe
// data passes through the 30-step cordic lanes, then the matrix, row and merge stages
// rst_n synchronously clears the stage valid bits only
// out_stall while out_valid freezes every stage at once; in_stall = out_valid & out_stall
module euler_rotate_3d_point #(
  parameter int COORD_BITS = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic [ANGLE_BITS-1:0]        in_angle_x,
  input  logic [ANGLE_BITS-1:0]        in_angle_y,
  input  logic [ANGLE_BITS-1:0]        in_angle_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_rot_x,
  output logic signed [COORD_BITS-1:0] out_rot_y,
  output logic signed [COORD_BITS-1:0] out_rot_z,
  output logic                         out_saturated
);

  localparam int CW = COORD_BITS;
  localparam int TRIG_LAT = erp_pkg::CORDIC_STEPS + 2;
  localparam int COORD_LAT = TRIG_LAT + 2;
  localparam int LAT = COORD_LAT + 3;

  logic             en;
  logic [LAT-1:0]   v_r;
  logic signed [CW-1:0] cd_r [0:COORD_LAT-1][0:2];

  assign en = !(v_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0][0] <= in_coord_x;
      cd_r[0][1] <= in_coord_y;
      cd_r[0][2] <= in_coord_z;
      for (int k = 1; k < COORD_LAT; k++) begin
        cd_r[k] <= cd_r[k-1];
      end
    end
  end

  erp_pkg::trig_t cx, sx, cy, sy, cz, sz;

  erp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_x (
    .clk(clk), .en(en), .angle(in_angle_x), .cos_o(cx), .sin_o(sx)
  );
  erp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_y (
    .clk(clk), .en(en), .angle(in_angle_y), .cos_o(cy), .sin_o(sy)
  );
  erp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_z (
    .clk(clk), .en(en), .angle(in_angle_z), .cos_o(cz), .sin_o(sz)
  );

  erp_pkg::mat_t m [0:8];

  erp_matrix u_matrix (
    .clk(clk), .en(en), .cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
    .m_o(m)
  );

  logic signed [CW-1:0] rot [0:2];
  logic [2:0]           sat;

  for (genvar r = 0; r < 3; r++) begin : g_row
    erp_pkg::mat_t mrow [0:2];
    assign mrow[0] = m[3*r];
    assign mrow[1] = m[3*r+1];
    assign mrow[2] = m[3*r+2];
    erp_row #(.COORD_BITS(CW)) u_row (
      .clk(clk), .en(en), .m(mrow), .p(cd_r[COORD_LAT-1]),
      .rot_o(rot[r]), .sat_o(sat[r])
    );
  end

  logic signed [CW-1:0] rx_r, ry_r, rz_r;
  logic                 sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= rot[0];
      ry_r  <= rot[1];
      rz_r  <= rot[2];
      sat_r <= |sat;
    end
  end

  assign out_valid     = v_r[LAT-1];
  assign out_rot_x     = rx_r;
  assign out_rot_y     = ry_r;
  assign out_rot_z     = rz_r;
  assign out_saturated = sat_r;

endmodule

// ===== rtl/core/erp_cordic.sv =====
module erp_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output erp_pkg::trig_t        cos_o,
  output erp_pkg::trig_t        sin_o
);

  localparam int N = erp_pkg::CORDIC_STEPS;
  localparam int W = erp_pkg::CW_BITS;
  localparam int TW = erp_pkg::TRIG_BITS;

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [W-1:0] z_r [0:N];
  logic [1:0]          q_r [0:N];
  erp_pkg::trig_t      c_r;
  erp_pkg::trig_t      s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= W'(erp_pkg::CORDIC_GAIN_Q30);
      y_r[0] <= '0;
      z_r[0] <= W'({angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
      q_r[0] <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = W'(erp_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  logic signed [W-1:0] cx_full;
  logic signed [W-1:0] sy_full;
  erp_pkg::trig_t      c_v;
  erp_pkg::trig_t      s_v;
  assign cx_full = (x_r[N] + W'(8192)) >>> 14;
  assign sy_full = (y_r[N] + W'(8192)) >>> 14;
  assign c_v = cx_full[TW-1:0];
  assign s_v = sy_full[TW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[N])
        erp_pkg::QUAD_0: begin c_r <= c_v;  s_r <= s_v;  end
        erp_pkg::QUAD_1: begin c_r <= -s_v; s_r <= c_v;  end
        erp_pkg::QUAD_2: begin c_r <= -c_v; s_r <= -s_v; end
        default:         begin c_r <= s_v;  s_r <= -c_v; end
      endcase
    end
  end

  assign cos_o = c_r;
  assign sin_o = s_r;

endmodule

// ===== rtl/core/erp_matrix.sv =====
module erp_matrix (
  input  logic           clk,
  input  logic           en,
  input  erp_pkg::trig_t cx,
  input  erp_pkg::trig_t sx,
  input  erp_pkg::trig_t cy,
  input  erp_pkg::trig_t sy,
  input  erp_pkg::trig_t cz,
  input  erp_pkg::trig_t sz,
  output erp_pkg::mat_t  m_o [0:8]
);

  localparam int TW = erp_pkg::TRIG_BITS;
  localparam int MW = erp_pkg::MAT_BITS;
  localparam int PW = 2 * TW;

  function automatic erp_pkg::trig_t rmul(erp_pkg::trig_t a, erp_pkg::trig_t b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + PW'(32768)) >>> 16;
    return p[TW-1:0];
  endfunction

  erp_pkg::trig_t czcy_r, szcx_r, czsy_r, szsx_r, szsy_r, czsx_r, czcx_r;
  erp_pkg::trig_t szcy_r, cysx_r, cycx_r, sx_r, cx_r, sy_r;
  erp_pkg::mat_t  m_r [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      czcy_r <= rmul(cz, cy);
      szcx_r <= rmul(sz, cx);
      czsy_r <= rmul(cz, sy);
      szsx_r <= rmul(sz, sx);
      szsy_r <= rmul(sz, sy);
      czsx_r <= rmul(cz, sx);
      czcx_r <= rmul(cz, cx);
      szcy_r <= rmul(sz, cy);
      cysx_r <= rmul(cy, sx);
      cycx_r <= rmul(cy, cx);
      sx_r   <= sx;
      cx_r   <= cx;
      sy_r   <= sy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= MW'(czcy_r);
      m_r[1] <= MW'(szcx_r) + MW'(rmul(czsy_r, sx_r));
      m_r[2] <= MW'(szsx_r) - MW'(rmul(czsy_r, cx_r));
      m_r[3] <= -MW'(szcy_r);
      m_r[4] <= MW'(czcx_r) - MW'(rmul(szsy_r, sx_r));
      m_r[5] <= MW'(czsx_r) + MW'(rmul(szsy_r, cx_r));
      m_r[6] <= MW'(sy_r);
      m_r[7] <= -MW'(cysx_r);
      m_r[8] <= MW'(cycx_r);
    end
  end

  assign m_o = m_r;

endmodule

// ===== rtl/core/erp_row.sv =====
module erp_row #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  erp_pkg::mat_t                m [0:2],
  input  logic signed [COORD_BITS-1:0] p [0:2],
  output logic signed [COORD_BITS-1:0] rot_o,
  output logic                         sat_o
);

  localparam int CW = COORD_BITS;
  localparam int MW = erp_pkg::MAT_BITS;
  localparam int PHW = CW - 15;
  localparam int HW = MW + PHW;
  localparam int LW = MW + 17;
  localparam int SW = HW + 2;
  localparam int TOTW = SW + 16;

  logic signed [HW-1:0] mh_r [0:2];
  logic signed [LW-1:0] ml_r [0:2];
  logic signed [CW-1:0] rot_r;
  logic                 sat_r;

  for (genvar j = 0; j < 3; j++) begin : g_prod
    logic signed [PHW-1:0] ph;
    logic signed [16:0]    pl;
    assign ph = PHW'(p[j] >>> 16);
    assign pl = $signed({1'b0, p[j][15:0]});
    always_ff @(posedge clk) begin
      if (en) begin
        mh_r[j] <= HW'(m[j]) * HW'(ph);
        ml_r[j] <= LW'(m[j]) * LW'(pl);
      end
    end
  end

  logic signed [TOTW-1:0] sumh;
  logic signed [TOTW-1:0] suml;
  logic signed [TOTW-1:0] v;
  logic                   fits;

  assign sumh = (TOTW'(mh_r[0]) + TOTW'(mh_r[1]) + TOTW'(mh_r[2])) <<< 16;
  assign suml = TOTW'(ml_r[0]) + TOTW'(ml_r[1]) + TOTW'(ml_r[2]);
  assign v = (sumh + suml + TOTW'(32768)) >>> 16;
  assign fits = (v[TOTW-1:CW-1] == '0) || (v[TOTW-1:CW-1] == '1);

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= !fits;
      if (fits) begin
        rot_r <= v[CW-1:0];
      end else begin
        rot_r <= v[TOTW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  assign rot_o = rot_r;
  assign sat_o = sat_r;

endmodule

// ===== rtl/core/erp_checker.sv =====
module erp_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_rot_x,
  input logic                  out_saturated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rot_x) && $stable(out_saturated))
    else $error("stalled result changed");

  a_stall: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind euler_rotate_3d_point erp_checker #(.COORD_BITS(COORD_BITS)) u_erp_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_rot_x(out_rot_x), .out_saturated(out_saturated)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CB = 32;
  localparam int AB = 16;
  localparam int STEPS = 30;
  localparam longint GAIN = 652032874;
  localparam int LATENCY = 37;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] rx;
    logic signed [CB-1:0] ry;
    logic signed [CB-1:0] rz;
    logic sat;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_coord_x = '0;
  logic signed [CB-1:0] in_coord_y = '0;
  logic signed [CB-1:0] in_coord_z = '0;
  logic [AB-1:0] in_angle_x = '0;
  logic [AB-1:0] in_angle_y = '0;
  logic [AB-1:0] in_angle_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] out_rot_x;
  logic signed [CB-1:0] out_rot_y;
  logic signed [CB-1:0] out_rot_z;
  logic out_saturated;

  rot_result_t expected_rots[$];
  int mismatches = 0;
  int points_sent = 0;
  int rots_checked = 0;
  int sat_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  euler_rotate_3d_point #(.COORD_BITS(CB), .ANGLE_BITS(AB)) dut (.*);

  always #5 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round16(longint v);
    return floor_shift(v + 32768, 16);
  endfunction

  function automatic longint atan_step(int i);
    longint tab[STEPS] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    return tab[i];
  endfunction

  task automatic cos_sin(input logic [AB-1:0] ang, output longint cv, output longint sv);
    logic [1:0] quad;
    longint z, x, y, dx, dy, c, s;
    quad = ang[AB-1:AB-2];
    z = longint'(ang[AB-3:0]) << (32 - AB);
    x = GAIN;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = floor_shift(x + 8192, 14);
    s = floor_shift(y + 8192, 14);
    case (quad)
      erp_pkg::QUAD_0: begin cv = c; sv = s; end
      erp_pkg::QUAD_1: begin cv = -s; sv = c; end
      erp_pkg::QUAD_2: begin cv = -c; sv = -s; end
      default: begin cv = s; sv = -c; end
    endcase
  endtask

  task automatic predict_rotation(input logic signed [CB-1:0] px, py, pz,
                                  input logic [AB-1:0] ax, ay, az);
    longint cx, sx, cy, sy, cz, sz, v, hi, lo, ph;
    longint m[3][3];
    longint p[3];
    longint comp[3];
    rot_result_t r;
    p[0] = px; p[1] = py; p[2] = pz;
    cos_sin(ax, cx, sx);
    cos_sin(ay, cy, sy);
    cos_sin(az, cz, sz);
    m[0][0] = round16(cz * cy);
    m[0][1] = round16(sz * cx) + round16(round16(cz * sy) * sx);
    m[0][2] = round16(sz * sx) - round16(round16(cz * sy) * cx);
    m[1][0] = -round16(sz * cy);
    m[1][1] = round16(cz * cx) - round16(round16(sz * sy) * sx);
    m[1][2] = round16(cz * sx) + round16(round16(sz * sy) * cx);
    m[2][0] = sy;
    m[2][1] = -round16(cy * sx);
    m[2][2] = round16(cy * cx);
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hi = 0; lo = 0;
      for (int j = 0; j < 3; j++) begin
        ph = floor_shift(p[j], 24);
        hi += m[i][j] * ph;
        lo += m[i][j] * (p[j] - ph * 16777216);
      end
      v = hi * 256 + floor_shift(lo + 32768, 16);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; r.sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; r.sat = 1'b1;
      end
      comp[i] = v;
    end
    r.rx = comp[0][CB-1:0];
    r.ry = comp[1][CB-1:0];
    r.rz = comp[2][CB-1:0];
    expected_rots = {expected_rots, r};
  endtask

  task automatic send_point(input logic signed [CB-1:0] px, py, pz,
                            input logic [AB-1:0] ax, ay, az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= px; in_coord_y <= py; in_coord_z <= pz;
    in_angle_x <= ax; in_angle_y <= ay; in_angle_z <= az;
    predict_rotation(px, py, pz, ax, ay, az);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $signed($urandom);
      1: return $signed($urandom_range(65536 * 200)) - 32'sd6553600;
      2: return $signed({{8{1'($urandom_range(1))}}, 24'($urandom)});
      default: return $signed($urandom_range(262144)) - 32'sd131072;
    endcase
  endfunction

  function automatic logic [AB-1:0] rand_angle();
    if ($urandom_range(7) == 0)
      return AB'($urandom_range(3) << (AB - 2));
    return AB'($urandom);
  endfunction

  task automatic test_directed();
    logic signed [CB-1:0] cmax, cmin;
    cmax = {1'b0, {(CB-1){1'b1}}};
    cmin = {1'b1, {(CB-1){1'b0}}};
    send_point(0, 0, 0, 0, 0, 0);
    send_point(32'sh10000, 32'sh20000, -32'sh30000, 0, 0, 0);
    send_point(cmax, cmin, cmax, 0, 0, 0);
    send_point(cmin, cmin, cmin, 16'hffff, 16'hffff, 16'hffff);
    for (int q = 0; q < 4; q++) begin
      send_point(32'sh10000, 32'sh10000, 32'sh10000, AB'(q << 14), 0, 0);
      send_point(32'sh10000, 32'sh10000, 32'sh10000, 0, AB'(q << 14), 0);
      send_point(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, AB'(q << 14));
    end
    send_point(cmax, cmax, cmax, 16'h2000, 16'h2000, 16'h2000);
    send_point(cmin, cmax, cmin, 16'h6000, 16'hA000, 16'hE000);
    send_point(-1, 1, -1, 16'h3fff, 16'h4001, 16'hbfff);
    send_point(cmax, 0, 0, 16'h1000, 16'h1000, 0);
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(),
                 rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_drain_pause();
    test_random(20);
    stop_sending();
    wait (expected_rots.size() == 0);
    @(negedge clk);
    test_random(20);
  endtask

  always @(negedge clk) begin
    if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
      out_stall <= 1'b1;
    else
      out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    rot_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
      end else begin
        want = expected_rots.pop_front();
        rots_checked++;
        if (out_saturated) sat_seen++;
        if (out_rot_x !== want.rx || out_rot_y !== want.ry ||
            out_rot_z !== want.rz || out_saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d sat %0b got %0d %0d %0d sat %0b",
                     want.rx, want.ry, want.rz, want.sat,
                     out_rot_x, out_rot_y, out_rot_z, out_saturated);
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 82;
    test_directed();
    test_random(560);
    test_drain_pause();
    send_idle_pct = 82;
    recv_idle_pct = 14;
    test_random(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(560);
    stop_sending();
    wait (expected_rots.size() == 0);
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d points, checked %0d rotations, %0d saturated", points_sent,
             rots_checked, sat_seen);
    $display("covered all quadrants, extreme coordinates and three idle patterns");
    if (mismatches == 0 && expected_rots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
